>>> rtl/bbd_pkg.sv
// Shared types, constants and helper functions for the bilinear Bayer demosaic block.
// This package has no dependencies. Every other file in rtl/ imports it.
package bbd_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 11;

	localparam logic [DIM_W-1:0] DIM_MIN       = DIM_W'(2);
	localparam logic [DIM_W-1:0] WIDTH_MAX     = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX    = DIM_W'(MAX_HEIGHT);
	localparam logic [DIM_W-1:0] DIM_RESET     = DIM_W'(32);

	// Configuration register indexes.
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	// Input command codes.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic cmd;
		pix_t raw_pixel;
	} in_item_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic frame_end;
	} out_item_t;

	// Position of the center pixel within the frame.
	typedef struct packed {
		logic row_odd;
		logic col_odd;
		logic top;
		logic bot;
		logic lft;
		logic rgt;
	} pos_t;

	// 3x3 neighborhood around the center pixel, unmasked.
	typedef struct packed {
		pix_t ul;
		pix_t um;
		pix_t ur;
		pix_t l;
		pix_t ce;
		pix_t rr;
		pix_t dl;
		pix_t dm;
		pix_t dr;
	} win_t;

	function automatic pix_t avg2(input pix_t a, input pix_t b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PIX_W:1];
	endfunction

	function automatic pix_t avg4(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
		logic [PIX_W+1:0] s;
		s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
		return s[PIX_W+1:2];
	endfunction

endpackage

>>> rtl/bbd_line_ram.sv
// One line store of the demosaic block: a single-port-write, registered-read memory.
// Depends on bbd_pkg for the depth and pixel width.
module bbd_line_ram
	import bbd_pkg::*;
(
	input  logic             clk,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output pix_t             rd_data,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  pix_t             wr_data
);

	pix_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read so a stalled consumer keeps its value.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/bbd_interp.sv
// Bilinear color reconstruction for one center pixel of the 3x3 window.
// Depends on bbd_pkg for the window, position types and averaging functions.
module bbd_interp
	import bbd_pkg::*;
(
	input  win_t win,
	input  pos_t pos,
	output pix_t red,
	output pix_t green,
	output pix_t blue
);

	pix_t ul, um, ur, l, rr, dl, dm, dr;
	pix_t avg_h, avg_v, avg_cross, avg_diag;

	// Neighbors outside the frame read as zero.
	always_comb begin
		ul = (pos.top || pos.lft) ? '0 : win.ul;
		um = pos.top ? '0 : win.um;
		ur = (pos.top || pos.rgt) ? '0 : win.ur;
		l  = pos.lft ? '0 : win.l;
		rr = pos.rgt ? '0 : win.rr;
		dl = (pos.bot || pos.lft) ? '0 : win.dl;
		dm = pos.bot ? '0 : win.dm;
		dr = (pos.bot || pos.rgt) ? '0 : win.dr;
	end

	assign avg_h     = avg2(l, rr);
	assign avg_v     = avg2(um, dm);
	assign avg_cross = avg4(l, rr, um, dm);
	assign avg_diag  = avg4(ul, ur, dl, dr);

	always_comb begin
		case ({pos.row_odd, pos.col_odd})
			2'b00: begin // green on a green-blue row
				red   = avg_v;
				green = win.ce;
				blue  = avg_h;
			end
			2'b01: begin // blue
				red   = avg_diag;
				green = avg_cross;
				blue  = win.ce;
			end
			2'b10: begin // red
				red   = win.ce;
				green = avg_cross;
				blue  = avg_diag;
			end
			default: begin // green on a red-green row
				red   = avg_h;
				green = win.ce;
				blue  = avg_v;
			end
		endcase
	end

endmodule

>>> rtl/bayer_bilinear_demosaic.sv
// Bilinear 3x3 Bayer demosaic, top level. Uses bbd_pkg, bbd_line_ram and bbd_interp.
// Path: a result is built from the transfer that completes its window through the
// line-store read plus input register (stage 1), then the result register.
// Throughput: one input transfer per cycle, sustained while the output side keeps up.
// Reset: arst_n clears the counters, window and valid flags at once; line stores
// are not cleared, and input is accepted as soon as reset is released.
module bayer_bilinear_demosaic
	import bbd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	// Frame geometry registers.
	logic [DIM_W-1:0] width_q, height_q;

	// Input-side and output-side position counters. The input pair advances on each item
	// taken, the output pair only on one that yields a result. Whether an item yields a
	// result and whether it restarts the frame are settled before it enters the pipeline.
	logic [COL_W-1:0] in_col_q;
	logic [DIM_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;

	// Stage 1: the accepted item, next to the registered line-store data.
	logic             s1_valid_s1;
	pix_t             x_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1;
	logic             fend_s1;
	pos_t             pos_s1;

	// The two most recent window columns; the newest column comes from stage 1.
	pix_t win_c1_q [3];
	pix_t win_c2_q [3];

	pix_t up_rd, mid_rd;

	logic             in_fire, drain, take, emit, s1_adv;
	logic             in_col_last, out_col_last, out_row_last, fend;
	logic [DIM_W-1:0] in_col_inc, out_col_inc, out_row_inc;
	pix_t             x_in;
	pos_t             pos_in;
	win_t             win;
	pix_t             red, green, blue;
	logic [DIM_W-1:0] cfg_clamped;

	// ------------------------------------------------------------------
	// Handshake. Stage 1 moves on whenever its result (if any) has room in
	// the output register; an item that yields no result always moves on.
	// ------------------------------------------------------------------
	assign s1_adv   = s1_valid_s1 && (!emit_s1 || !out_valid || out_ready);
	assign in_ready = !s1_valid_s1 || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Accept-time decisions. Once every row of the frame is in, any item is a
	// drain step carrying zero. A drain command that arrives early is dropped.
	// ------------------------------------------------------------------
	assign drain = in_row_q >= height_q;
	assign take  = !(in_data.cmd == CMD_DRAIN && !drain);
	assign x_in  = drain ? '0 : in_data.raw_pixel;
	assign emit  = (in_row_q >= DIM_W'(2)) || (in_row_q == DIM_W'(1) && in_col_q != '0);

	assign in_col_inc   = DIM_W'(in_col_q) + DIM_W'(1);
	assign in_col_last  = in_col_inc >= width_q;
	assign out_col_inc  = DIM_W'(out_col_q) + DIM_W'(1);
	assign out_row_inc  = DIM_W'(out_row_q) + DIM_W'(1);
	assign out_col_last = out_col_inc >= width_q;
	assign out_row_last = out_row_inc >= height_q;
	assign fend         = out_col_last && out_row_last;

	always_comb begin
		pos_in.row_odd = out_row_q[0];
		pos_in.col_odd = out_col_q[0];
		pos_in.top     = out_row_q == '0;
		pos_in.bot     = out_row_last;
		pos_in.lft     = out_col_q == '0;
		pos_in.rgt     = out_col_last;
	end

	// Register writes clamp the value into range.
	always_comb begin
		if (cfg_data < DIM_MIN) begin
			cfg_clamped = DIM_MIN;
		end else if (cfg_index == CFG_IMAGE_WIDTH && cfg_data > WIDTH_MAX) begin
			cfg_clamped = WIDTH_MAX;
		end else if (cfg_index == CFG_IMAGE_HEIGHT && cfg_data > HEIGHT_MAX) begin
			cfg_clamped = HEIGHT_MAX;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_clamped;
				CFG_IMAGE_HEIGHT: height_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// Position counters. A register write restarts the frame, and so does the
	// item that produces the frame's last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (in_fire && take) begin
			if (emit && fend) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + DIM_W'(1);
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
				if (emit) begin
					if (out_col_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_inc[ROW_W-1:0];
					end else begin
						out_col_q <= out_col_inc[COL_W-1:0];
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Line stores. Both are read at the input column when an item is taken,
	// and written at that column when the item leaves stage 1: the upper
	// store receives the old middle sample, the middle store the new one.
	// Consecutive items hit different columns within a frame. Across a frame
	// restart the first item reads column 0 while the frame's last item
	// writes it; that read returns the old entry, which only lands in
	// neighbors above the first row and is masked to zero anyway.
	// ------------------------------------------------------------------
	bbd_line_ram u_upper (
		.clk     (clk),
		.rd_en   (in_fire && take),
		.rd_addr (in_col_q),
		.rd_data (up_rd),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (mid_rd)
	);

	bbd_line_ram u_middle (
		.clk     (clk),
		.rd_en   (in_fire && take),
		.rd_addr (in_col_q),
		.rd_data (mid_rd),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (x_s1)
	);

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			s1_valid_s1 <= take;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && take) begin
			x_s1    <= x_in;
			col_s1  <= in_col_q;
			emit_s1 <= emit;
			fend_s1 <= emit && fend;
			pos_s1  <= pos_in;
		end
	end

	// ------------------------------------------------------------------
	// Window. The center sees the window as it stands after this item's
	// shift: the two stored columns plus the new column (upper, middle, new
	// sample). The window clears after the frame's last result and on a register write.
	// ------------------------------------------------------------------
	always_comb begin
		win.ul = win_c1_q[0];
		win.um = win_c2_q[0];
		win.ur = up_rd;
		win.l  = win_c1_q[1];
		win.ce = win_c2_q[1];
		win.rr = mid_rd;
		win.dl = win_c1_q[2];
		win.dm = win_c2_q[2];
		win.dr = x_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_c1_q <= '{default: '0};
			win_c2_q <= '{default: '0};
		end else if (cfg_we || (s1_adv && fend_s1)) begin
			win_c1_q <= '{default: '0};
			win_c2_q <= '{default: '0};
		end else if (s1_adv) begin
			win_c1_q <= win_c2_q;
			win_c2_q <= '{up_rd, mid_rd, x_s1};
		end
	end

	bbd_interp u_interp (
		.win   (win),
		.pos   (pos_s1),
		.red   (red),
		.green (green),
		.blue  (blue)
	);

	// Result register: a finished result waits here while the input side
	// keeps accepting items that produce no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			out_data.red       <= red;
			out_data.green     <= green;
			out_data.blue      <= blue;
			out_data.frame_end <= fend_s1;
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_geometry_range: assert property (@(posedge clk) disable iff (!arst_n)
		width_q >= DIM_MIN && width_q <= WIDTH_MAX &&
		height_q >= DIM_MIN && height_q <= HEIGHT_MAX)
		else $error("frame geometry register out of range");

	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		DIM_W'(in_col_q) < width_q)
		else $error("input column beyond the frame width");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && emit_s1 && out_valid && !out_ready) |=>
		(s1_valid_s1 && $stable(col_s1) && $stable(x_s1)))
		else $error("stage 1 item lost while the result register was full");

	a_fend_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && take && emit && fend && !cfg_we) |=>
		(in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("counters did not restart after the frame's last result");

endmodule
